>>> rtl/dsparse_pkg.sv
// ---------------------------------------------------------------------------
// dsparse_pkg: shared types and constants of the duration string parser
// Payload structs of both channels, token classes and grammar phases.
// ---------------------------------------------------------------------------
package dsparse_pkg;

    localparam int FIELD_BITS     = 31;
    localparam int DEF_VALUE_BITS = 31;

    typedef struct packed {
        logic [7:0] ch;
        logic       ch_present;
        logic       last;
    } t_in;

    typedef struct packed {
        logic                  valid_res;
        logic                  negative;
        logic [FIELD_BITS-1:0] weeks;
        logic [FIELD_BITS-1:0] days;
        logic [FIELD_BITS-1:0] hours;
        logic [FIELD_BITS-1:0] minutes;
        logic [FIELD_BITS-1:0] seconds;
    } t_out;

    // Class of a non-digit character
    typedef enum logic [3:0] {
        SYM_PLUS,
        SYM_MINUS,
        SYM_P,
        SYM_T,
        SYM_D,
        SYM_W,
        SYM_H,
        SYM_M,
        SYM_S,
        SYM_UPPER,
        SYM_BAD
    } t_sym;

    typedef enum logic [1:0] {
        TOK_NUM,
        TOK_CHAR,
        TOK_END
    } t_tok;

    typedef enum logic [3:0] {
        PH_START,
        PH_NEED_P,
        PH_AFTER_P,
        PH_DATE_UNIT,
        PH_AFTER_D,
        PH_T_NUM,
        PH_T_UNIT,
        PH_M_NUM,
        PH_M_UNIT,
        PH_S_NUM,
        PH_S_UNIT,
        PH_DONE,
        PH_DEAD
    } t_phase;

    // Tokens produced by one input item, applied in order num, char, end
    typedef struct packed {
        logic num_vld;
        logic chr_vld;
        t_sym sym;
        logic end_vld;
    } t_tok_ctl;

    localparam int CTL_BITS = $bits(t_tok_ctl);

endpackage

>>> rtl/duration_string_parser.sv
// ---------------------------------------------------------------------------
// duration_string_parser: streaming duration string parser
// Parses strings such as -P3DT4H5M and reports sign and unit counts.
// ---------------------------------------------------------------------------
// Input channel (i_valid / o_stall, payload i_data): one Latin-1 character
// per transfer, with ch_present low for a bare end marker and last high on
// the final item of a string. Output channel (o_valid / i_stall, payload
// o_data): one result per string, given for the item marked last.
// Throughput: one input item per cycle while the queue is not full. The tokenizer builds digit
// runs with a times-ten add and pushes token bundles into a two-entry queue;
// the grammar engine applies up to three tokens per bundle combinationally, in order.
// A result passes from the queue through the grammar engine into the output
// register, once that register is free.
// Reset (synchronous, active low) empties the queue and the output register
// and returns the parser to the start of a string.
// While the receiver stalls, the result waits in the output register; the
// engine keeps consuming bundles until it meets the next string end, and
// input is stalled only once the queue is full.
// ---------------------------------------------------------------------------
module duration_string_parser import dsparse_pkg::*; #(
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    localparam int QW = CTL_BITS + VALUE_BITS;

    logic                  push;
    logic                  pop;
    logic                  q_full;
    logic                  q_empty;
    t_tok_ctl              f_ctl;
    logic [VALUE_BITS-1:0] f_num;
    t_tok_ctl              b_ctl;
    logic [VALUE_BITS-1:0] b_num;
    logic [QW-1:0]         q_rdata;

    dsparse_front #(.VALUE_BITS(VALUE_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_data   (i_data),
        .i_q_full (q_full),
        .o_stall  (o_stall),
        .o_push   (push),
        .o_ctl    (f_ctl),
        .o_num    (f_num)
    );

    dsparse_fifo #(.WIDTH(QW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata ({f_ctl, f_num}),
        .i_pop   (pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    assign b_ctl = t_tok_ctl'(q_rdata[QW-1:VALUE_BITS]);
    assign b_num = q_rdata[VALUE_BITS-1:0];

    dsparse_back #(.VALUE_BITS(VALUE_BITS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_ctl     (b_ctl),
        .i_num     (b_num),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_data    (o_data)
    );

endmodule

>>> rtl/dsparse_front.sv
// ---------------------------------------------------------------------------
// dsparse_front: character tokenizer
// Accepts one character per cycle unless the queue is full, builds digit runs and emits token bundles.
// ---------------------------------------------------------------------------
module dsparse_front import dsparse_pkg::*; #(
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  t_in                   i_data,
    input  logic                  i_q_full,
    output logic                  o_stall,
    output logic                  o_push,
    output t_tok_ctl              o_ctl,
    output logic [VALUE_BITS-1:0] o_num
);

    localparam int PW = VALUE_BITS + 4;

    logic                  r_run;
    logic                  r_ovf;
    logic [VALUE_BITS-1:0] r_acc;
    logic                  n_run;
    logic                  n_ovf;
    logic [VALUE_BITS-1:0] n_acc;

    logic                  accept;
    logic                  is_dig;
    logic [VALUE_BITS-1:0] base_acc;
    logic                  base_ovf;
    logic [PW-1:0]         prod;

    function automatic t_sym f_class(input logic [7:0] c);
        t_sym s;
        s = SYM_BAD;
        if (c == 8'h2B) begin
            s = SYM_PLUS;
        end else if (c == 8'h2D) begin
            s = SYM_MINUS;
        end else if (c == 8'h50) begin
            s = SYM_P;
        end else if (c == 8'h54) begin
            s = SYM_T;
        end else if (c == 8'h44) begin
            s = SYM_D;
        end else if (c == 8'h57) begin
            s = SYM_W;
        end else if (c == 8'h48) begin
            s = SYM_H;
        end else if (c == 8'h4D) begin
            s = SYM_M;
        end else if (c == 8'h53) begin
            s = SYM_S;
        end else if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'hC0 && c <= 8'hD6) ||
                     (c >= 8'hD8 && c <= 8'hDE)) begin
            s = SYM_UPPER;
        end
        return s;
    endfunction

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign is_dig  = i_data.ch_present && (i_data.ch >= 8'h30) && (i_data.ch <= 8'h39);

    // A new digit run starts from zero
    assign base_acc = r_run ? r_acc : '0;
    assign base_ovf = r_run ? r_ovf : 1'b0;
    assign prod     = (PW'(base_acc) << 3) + (PW'(base_acc) << 1) + PW'(i_data.ch[3:0]);

    always_comb begin
        n_run = r_run;
        n_ovf = r_ovf;
        n_acc = r_acc;
        o_ctl = '{num_vld: 1'b0, chr_vld: 1'b0, sym: SYM_BAD, end_vld: 1'b0};
        o_num = r_ovf ? '0 : r_acc;
        if (is_dig) begin
            n_run = 1'b1;
            n_ovf = base_ovf;
            n_acc = base_acc;
            if (!base_ovf) begin
                if (|prod[PW-1:VALUE_BITS]) begin
                    n_ovf = 1'b1;
                end else begin
                    n_acc = prod[VALUE_BITS-1:0];
                end
            end
        end else if (i_data.ch_present) begin
            o_ctl.num_vld = r_run;
            o_ctl.chr_vld = 1'b1;
            o_ctl.sym     = f_class(i_data.ch);
            n_run         = 1'b0;
        end
        if (i_data.last) begin
            // flush a run that ends with this item's digit
            if (is_dig) begin
                o_ctl.num_vld = 1'b1;
                o_num         = n_ovf ? '0 : n_acc;
            end else if (!i_data.ch_present) begin
                // a bare end marker closes an open run
                o_ctl.num_vld = r_run;
            end
            o_ctl.end_vld = 1'b1;
            n_run         = 1'b0;
            n_ovf         = 1'b0;
            n_acc         = '0;
        end
    end

    assign o_push = accept && (o_ctl.num_vld || o_ctl.chr_vld || o_ctl.end_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_ovf <= 1'b0;
            r_acc <= '0;
        end else if (accept) begin
            r_run <= n_run;
            r_ovf <= n_ovf;
            r_acc <= n_acc;
        end
    end

endmodule

>>> rtl/dsparse_fifo.sv
// ---------------------------------------------------------------------------
// dsparse_fifo: two-entry token queue
// Decouples the tokenizer from the grammar engine.
// ---------------------------------------------------------------------------
module dsparse_fifo import dsparse_pkg::*; #(
    parameter int WIDTH = CTL_BITS + DEF_VALUE_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty,
    output logic             o_full
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_cnt;

    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> rtl/dsparse_back.sv
// ---------------------------------------------------------------------------
// dsparse_back: duration grammar engine
// Applies token bundles to the grammar and registers the result.
// ---------------------------------------------------------------------------
module dsparse_back import dsparse_pkg::*; #(
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_empty,
    input  t_tok_ctl              i_ctl,
    input  logic [VALUE_BITS-1:0] i_num,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out                  o_data
);

    typedef struct packed {
        t_phase                phase;
        logic [VALUE_BITS-1:0] pend;
        logic                  vld;
        logic                  neg;
        logic                  fin;
        logic [VALUE_BITS-1:0] wk;
        logic [VALUE_BITS-1:0] dy;
        logic [VALUE_BITS-1:0] hr;
        logic [VALUE_BITS-1:0] mi;
        logic [VALUE_BITS-1:0] se;
    } t_gs;

    localparam t_gs GS_RESET = '{phase: PH_START, pend: '0, vld: 1'b1, neg: 1'b0,
                                 fin: 1'b0, wk: '0, dy: '0, hr: '0, mi: '0, se: '0};

    t_gs  r_gs;
    t_gs  n_gs;
    t_gs  gs_a;
    t_gs  gs_b;
    t_gs  gs_c;
    logic r_out_vld;
    t_out r_out;
    logic n_out_vld;
    t_out n_out;
    logic out_free;
    logic ok;

    function automatic t_gs f_fail(input t_gs s);
        t_gs n;
        n       = s;
        n.vld   = 1'b0;
        n.phase = PH_DEAD;
        return n;
    endfunction

    function automatic t_gs f_step(input t_gs s, input t_tok k, input t_sym c,
                                   input logic [VALUE_BITS-1:0] v);
        t_gs  n;
        logic is_num;
        logic is_end;
        logic is_ch;
        n      = s;
        is_num = (k == TOK_NUM);
        is_end = (k == TOK_END);
        is_ch  = (k == TOK_CHAR);
        if (is_ch && c == SYM_BAD) begin
            n = f_fail(s);
        end else begin
            case (s.phase)
                PH_START: begin
                    if (is_ch && c == SYM_PLUS) begin
                        n.phase = PH_NEED_P;
                    end else if (is_ch && c == SYM_MINUS) begin
                        n.neg   = 1'b1;
                        n.phase = PH_NEED_P;
                    end else if (is_ch && c == SYM_P) begin
                        n.phase = PH_AFTER_P;
                    end else begin
                        n = f_fail(s);
                    end
                end
                PH_NEED_P: begin
                    if (is_ch && c == SYM_P) n.phase = PH_AFTER_P;
                    else n = f_fail(s);
                end
                PH_AFTER_P: begin
                    if (is_ch && c == SYM_T) begin
                        n.phase = PH_T_NUM;
                    end else if (is_num) begin
                        n.pend  = v;
                        n.phase = PH_DATE_UNIT;
                    end else begin
                        n = f_fail(s);
                    end
                end
                PH_DATE_UNIT: begin
                    if (is_ch && c == SYM_D) begin
                        n.dy    = s.pend;
                        n.phase = PH_AFTER_D;
                    end else if (is_ch && c == SYM_W) begin
                        n.wk    = s.pend;
                        n.phase = PH_DONE;
                    end else begin
                        n = f_fail(s);
                    end
                end
                PH_AFTER_D: begin
                    // anything but T, the end or a bad character is swallowed here
                    if (is_end) n.fin = 1'b1;
                    else if (is_ch && c == SYM_T) n.phase = PH_T_NUM;
                    else n.phase = PH_DONE;
                end
                PH_T_NUM: begin
                    if (is_num) begin
                        n.pend  = v;
                        n.phase = PH_T_UNIT;
                    end else begin
                        n = f_fail(s);
                    end
                end
                PH_T_UNIT: begin
                    if (is_end) begin
                        n.fin = 1'b1;
                    end else if (is_ch && c == SYM_H) begin
                        n.hr    = s.pend;
                        n.phase = PH_M_NUM;
                    end else if (is_ch && c == SYM_M) begin
                        n.mi    = s.pend;
                        n.phase = PH_S_NUM;
                    end else if (is_ch && c == SYM_S) begin
                        n.se    = s.pend;
                        n.phase = PH_DONE;
                    end else begin
                        n.phase = PH_DONE;
                    end
                end
                PH_M_NUM: begin
                    if (is_end) begin
                        n.fin = 1'b1;
                    end else if (is_num) begin
                        n.pend  = v;
                        n.phase = PH_M_UNIT;
                    end else begin
                        n = f_fail(s);
                    end
                end
                PH_M_UNIT: begin
                    if (is_ch && c == SYM_M) begin
                        n.mi    = s.pend;
                        n.phase = PH_S_NUM;
                    end else begin
                        n = f_fail(s);
                    end
                end
                PH_S_NUM: begin
                    if (is_end) begin
                        n.fin = 1'b1;
                    end else if (is_num) begin
                        n.pend  = v;
                        n.phase = PH_S_UNIT;
                    end else begin
                        n = f_fail(s);
                    end
                end
                PH_S_UNIT: begin
                    if (is_ch && c == SYM_S) begin
                        n.se    = s.pend;
                        n.phase = PH_DONE;
                    end else begin
                        n = f_fail(s);
                    end
                end
                PH_DONE: begin
                    if (is_end) n.fin = 1'b1;
                    else n = f_fail(s);
                end
                default: begin
                    n = f_fail(s);
                end
            endcase
        end
        return n;
    endfunction

    assign out_free = !r_out_vld || !i_stall;
    // hold a bundle that ends a string until the output register frees up
    assign o_pop    = !i_q_empty && (!i_ctl.end_vld || out_free);

    // next state: up to three grammar steps per bundle
    always_comb begin
        gs_a = r_gs;
        if (i_ctl.num_vld) begin
            gs_a = f_step(r_gs, TOK_NUM, SYM_BAD, i_num);
        end
        gs_b = gs_a;
        if (i_ctl.chr_vld) begin
            gs_b = f_step(gs_a, TOK_CHAR, i_ctl.sym, i_num);
        end
        gs_c = gs_b;
        if (i_ctl.end_vld) begin
            gs_c = f_step(gs_b, TOK_END, SYM_BAD, i_num);
        end
        n_gs = r_gs;
        if (o_pop) begin
            n_gs = i_ctl.end_vld ? GS_RESET : gs_c;
        end
    end

    // outputs: result of the finished string
    always_comb begin
        ok                = gs_c.vld && gs_c.fin;
        n_out.valid_res   = ok;
        n_out.negative    = ok && gs_c.neg;
        n_out.weeks       = ok ? FIELD_BITS'(gs_c.wk) : '0;
        n_out.days        = ok ? FIELD_BITS'(gs_c.dy) : '0;
        n_out.hours       = ok ? FIELD_BITS'(gs_c.hr) : '0;
        n_out.minutes     = ok ? FIELD_BITS'(gs_c.mi) : '0;
        n_out.seconds     = ok ? FIELD_BITS'(gs_c.se) : '0;
        n_out_vld         = r_out_vld && i_stall;
        if (o_pop && i_ctl.end_vld) begin
            n_out_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gs      <= GS_RESET;
            r_out_vld <= 1'b0;
        end else begin
            r_gs      <= n_gs;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_ctl.end_vld) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

>>> rtl/dsparse_checker.sv
// ---------------------------------------------------------------------------
// dsparse_checker: port-level checks of the duration string parser
// Watches the output channel and the consistency of reported results.
// ---------------------------------------------------------------------------
module dsparse_checker import dsparse_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_valid,
    input logic i_stall,
    input t_out o_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_data))
        else $error("result changed while stalled");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.valid_res |->
            (!o_data.negative && o_data.weeks == '0 && o_data.days == '0 &&
             o_data.hours == '0 && o_data.minutes == '0 && o_data.seconds == '0))
        else $error("invalid result carries values");

    a_weeks_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.weeks != '0 |->
            (o_data.days == '0 && o_data.hours == '0 && o_data.minutes == '0 &&
             o_data.seconds == '0))
        else $error("week form mixed with other units");

endmodule

bind duration_string_parser dsparse_checker u_dsparse_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

>>> bench/tb_duration_string_parser.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_duration_string_parser: self-checking bench of the duration parser
// Streams a table of directed duration strings, then random well-formed,
// mangled and noise strings, with random sender gaps and receiver stalls.
// A behavioral parser predicts each result not typed into the table; results are compared in order.
// ---------------------------------------------------------------------------
module tb_duration_string_parser;
    import dsparse_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1700;
    localparam longint unsigned NUM_MAX = (64'd1 << DEF_VALUE_BITS) - 64'd1;
    localparam t_out NO_DURATION = '0;

    typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_CHOKE, RX_SPARSE} t_rx_mode;

    typedef struct {
        string text;
        bit    bare_end;
        int    idle_at;
        bit    typed;
        t_out  want;
    } t_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_in  i_data  = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_out o_data;

    duration_string_parser i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always #5 i_clk = ~i_clk;

    // Parser state of the prediction
    t_phase                ph;
    logic [FIELD_BITS-1:0] acc, pend;
    logic [FIELD_BITS-1:0] n_weeks, n_days, n_hours, n_minutes, n_seconds;
    bit                    ovf, in_run, ok_flag, neg_flag, ended_ok;

    t_out        expected_durations[$];
    byte unsigned text_buf[$];
    t_row        rows[$];

    int err_cnt         = 0;
    int results_checked = 0;
    int char_cnt        = 0;
    int strings_sent    = 0;
    int cycle_cnt       = 0;
    int burst_left      = 0;
    int rx_left         = 0;
    t_rx_mode rx_mode   = RX_FREE;

    task automatic clear_parse();
        ph        = PH_START;
        acc       = '0;
        pend      = '0;
        ovf       = 1'b0;
        in_run    = 1'b0;
        ok_flag   = 1'b1;
        neg_flag  = 1'b0;
        ended_ok  = 1'b0;
        n_weeks   = '0;
        n_days    = '0;
        n_hours   = '0;
        n_minutes = '0;
        n_seconds = '0;
    endtask

    task automatic kill_parse();
        ok_flag = 1'b0;
        ph      = PH_DEAD;
    endtask

    function automatic bit is_upper(byte unsigned c);
        return (c >= "A" && c <= "Z") || (c >= 8'hC0 && c <= 8'hD6) ||
               (c >= 8'hD8 && c <= 8'hDE);
    endfunction

    task automatic feed_token(t_tok kind, byte unsigned c, logic [FIELD_BITS-1:0] v);
        bit is_num, is_end, is_ch;
        is_num = (kind == TOK_NUM);
        is_end = (kind == TOK_END);
        is_ch  = (kind == TOK_CHAR);
        case (ph)
            PH_START: begin
                if (is_ch && c == "+") ph = PH_NEED_P;
                else if (is_ch && c == "-") begin
                    neg_flag = 1'b1;
                    ph = PH_NEED_P;
                end else if (is_ch && c == "P") ph = PH_AFTER_P;
                else kill_parse();
            end
            PH_NEED_P: begin
                if (is_ch && c == "P") ph = PH_AFTER_P;
                else kill_parse();
            end
            PH_AFTER_P: begin
                if (is_ch && c == "T") ph = PH_T_NUM;
                else if (is_num) begin
                    pend = v;
                    ph = PH_DATE_UNIT;
                end else kill_parse();
            end
            PH_DATE_UNIT: begin
                if (is_ch && c == "D") begin
                    n_days = pend;
                    ph = PH_AFTER_D;
                end else if (is_ch && c == "W") begin
                    n_weeks = pend;
                    ph = PH_DONE;
                end else kill_parse();
            end
            PH_AFTER_D: begin
                // swallow anything but T after the day count
                if (is_end) ended_ok = 1'b1;
                else if (is_ch && c == "T") ph = PH_T_NUM;
                else ph = PH_DONE;
            end
            PH_T_NUM: begin
                if (is_num) begin
                    pend = v;
                    ph = PH_T_UNIT;
                end else kill_parse();
            end
            PH_T_UNIT: begin
                if (is_end) ended_ok = 1'b1;
                else if (is_ch && c == "H") begin
                    n_hours = pend;
                    ph = PH_M_NUM;
                end else if (is_ch && c == "M") begin
                    n_minutes = pend;
                    ph = PH_S_NUM;
                end else if (is_ch && c == "S") begin
                    n_seconds = pend;
                    ph = PH_DONE;
                end else ph = PH_DONE;
            end
            PH_M_NUM: begin
                if (is_end) ended_ok = 1'b1;
                else if (is_num) begin
                    pend = v;
                    ph = PH_M_UNIT;
                end else kill_parse();
            end
            PH_M_UNIT: begin
                if (is_ch && c == "M") begin
                    n_minutes = pend;
                    ph = PH_S_NUM;
                end else kill_parse();
            end
            PH_S_NUM: begin
                if (is_end) ended_ok = 1'b1;
                else if (is_num) begin
                    pend = v;
                    ph = PH_S_UNIT;
                end else kill_parse();
            end
            PH_S_UNIT: begin
                if (is_ch && c == "S") begin
                    n_seconds = pend;
                    ph = PH_DONE;
                end else kill_parse();
            end
            PH_DONE: begin
                if (is_end) ended_ok = 1'b1;
                else kill_parse();
            end
            default: kill_parse();
        endcase
    endtask

    task automatic flush_run();
        if (in_run) begin
            in_run = 1'b0;
            feed_token(TOK_NUM, 8'd0, ovf ? '0 : acc);
        end
    endtask

    task automatic parse_char(input t_in item, output bit has_res, output t_out res);
        longint unsigned nxt;
        byte unsigned    c;
        c       = item.ch;
        has_res = 1'b0;
        res     = NO_DURATION;
        if (item.ch_present) begin
            if (c >= "0" && c <= "9") begin
                if (!in_run) begin
                    in_run = 1'b1;
                    acc    = '0;
                    ovf    = 1'b0;
                end
                if (!ovf) begin
                    nxt = {33'd0, acc} * 64'd10 + {56'd0, c} - 64'd48;
                    // an oversized run reads as zero
                    if (nxt > NUM_MAX) ovf = 1'b1;
                    else acc = nxt[FIELD_BITS-1:0];
                end
            end else begin
                flush_run();
                if (c == "+" || c == "-" || is_upper(c)) feed_token(TOK_CHAR, c, '0);
                else kill_parse();
            end
        end
        if (item.last) begin
            flush_run();
            feed_token(TOK_END, 8'd0, '0);
            if (ok_flag && ended_ok) begin
                res.valid_res = 1'b1;
                res.negative  = neg_flag;
                res.weeks     = n_weeks;
                res.days      = n_days;
                res.hours     = n_hours;
                res.minutes   = n_minutes;
                res.seconds   = n_seconds;
            end
            has_res = 1'b1;
            clear_parse();
        end
    endtask

    function automatic t_out dur(bit ok, bit neg, int unsigned w, int unsigned d,
                                 int unsigned h, int unsigned m, int unsigned s);
        t_out r;
        r.valid_res = ok;
        r.negative  = neg;
        r.weeks     = w[FIELD_BITS-1:0];
        r.days      = d[FIELD_BITS-1:0];
        r.hours     = h[FIELD_BITS-1:0];
        r.minutes   = m[FIELD_BITS-1:0];
        r.seconds   = s[FIELD_BITS-1:0];
        return r;
    endfunction

    task automatic add_row(string text, bit bare_end, int idle_at, bit typed, t_out want);
        t_row r;
        r.text     = text;
        r.bare_end = bare_end;
        r.idle_at  = idle_at;
        r.typed    = typed;
        r.want     = want;
        rows.push_back(r);
    endtask

    // Drive one item and hold it until the transfer; open a new burst when due.
    task automatic send_item(t_in item, bit typed, t_out want);
        bit   has_res;
        t_out res;
        int   gap_len;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 60);
            gap_len = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
            if (gap_len != 0) begin
                i_valid <= 1'b0;
                repeat (gap_len) @(negedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_data  <= item;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        parse_char(item, has_res, res);
        if (has_res) expected_durations.push_back(typed ? want : res);
        if (item.ch_present) char_cnt++;
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic send_string(bit bare_end, int idle_at, bit typed, t_out want);
        t_in item;
        for (int k = 0; k < text_buf.size(); k++) begin
            if (k == idle_at) begin
                item.ch         = 8'($urandom);
                item.ch_present = 1'b0;
                item.last       = 1'b0;
                send_item(item, 1'b0, NO_DURATION);
            end
            item.ch         = text_buf[k];
            item.ch_present = 1'b1;
            item.last       = !bare_end && (k == text_buf.size() - 1);
            send_item(item, typed, want);
        end
        if (bare_end) begin
            item.ch         = 8'($urandom);
            item.ch_present = 1'b0;
            item.last       = 1'b1;
            send_item(item, typed, want);
        end
        strings_sent++;
    endtask

    // Hold the sender until every pending result is out.
    task automatic drain_wait();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (expected_durations.size() != 0) @(negedge i_clk);
    endtask

    function automatic byte unsigned noise_char();
        string pool;
        pool = "PTDWHMS+-0123456789";
        if ($urandom_range(0, 2) == 0) return 8'($urandom);
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    task automatic push_number();
        string digits;
        case ($urandom_range(0, 15))
            0: digits = "2147483647";
            1: digits = "2147483648";
            2: begin
                digits = "";
                repeat ($urandom_range(11, 24))
                    digits = {digits, $sformatf("%0d", $urandom_range(0, 9))};
            end
            3: digits = $sformatf("000%0d", $urandom_range(0, 99));
            4, 5: digits = $sformatf("%0d", $urandom);
            default: digits = $sformatf("%0d", $urandom_range(0, 999));
        endcase
        for (int k = 0; k < digits.len(); k++) text_buf.push_back(digits[k]);
    endtask

    task automatic push_time();
        int shape;
        shape = $urandom_range(0, 5);
        text_buf.push_back("T");
        if (shape <= 2) begin
            push_number();
            text_buf.push_back("H");
        end
        if (shape inside {1, 2, 3, 4}) begin
            push_number();
            text_buf.push_back("M");
        end
        if (shape inside {2, 4, 5}) begin
            push_number();
            text_buf.push_back("S");
        end
    endtask

    task automatic build_text();
        int pos;
        text_buf.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(0, 8)) text_buf.push_back(noise_char());
            return;
        end
        case ($urandom_range(0, 3))
            1: text_buf.push_back("+");
            2: text_buf.push_back("-");
            default: ;
        endcase
        text_buf.push_back("P");
        case ($urandom_range(0, 2))
            0: begin
                push_number();
                text_buf.push_back("W");
            end
            1: begin
                push_number();
                text_buf.push_back("D");
                if ($urandom_range(0, 1)) push_time();
            end
            default: push_time();
        endcase
        // break a share of the strings
        if ($urandom_range(0, 4) == 0) begin
            pos = $urandom_range(0, text_buf.size() - 1);
            case ($urandom_range(0, 4))
                0: text_buf[pos] = 8'($urandom);
                1: text_buf.insert(pos, noise_char());
                2: text_buf.delete(pos);
                3: while (text_buf.size() > pos) void'(text_buf.pop_back());
                default: text_buf.push_back(noise_char());
            endcase
        end
    endtask

    // Receiver stall pattern: segments of free flow, coin flips, long chokes and sparse stalls
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(8, 80);
        end
        rx_left--;
        case (rx_mode)
            RX_FREE:  i_stall <= 1'b0;
            RX_COIN:  i_stall <= 1'($urandom_range(0, 1));
            RX_CHOKE: i_stall <= (rx_left % 16) < 11;
            default:  i_stall <= ($urandom_range(0, 7) == 0);
        endcase
    end

    function automatic void check_field(string name, longint unsigned want_v,
                                        longint unsigned got_v);
        if (want_v != got_v) begin
            err_cnt++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_durations.size() == 0) begin
                err_cnt++;
                $display("%0t: result with none pending, expected nothing, got %h",
                         $time, o_data);
            end else begin
                want = expected_durations.pop_front();
                check_field("valid_res", want.valid_res, o_data.valid_res);
                check_field("negative", want.negative, o_data.negative);
                check_field("weeks", want.weeks, o_data.weeks);
                check_field("days", want.days, o_data.days);
                check_field("hours", want.hours, o_data.hours);
                check_field("minutes", want.minutes, o_data.minutes);
                check_field("seconds", want.seconds, o_data.seconds);
                results_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results pending", $time,
                     expected_durations.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int rnd_items;
        int idle_at;
        bit bare;
        bit drained;
        rnd_items = 0;
        drained   = 1'b0;
        clear_parse();

        add_row("P1W", 0, -1, 1, dur(1, 0, 1, 0, 0, 0, 0));
        add_row("-P3DT4H5M", 1, -1, 0, NO_DURATION);
        add_row("+PT1H2M3S", 0, -1, 0, NO_DURATION);
        add_row("PT2147483647S", 0, -1, 1, dur(1, 0, 0, 0, 0, 0, 2147483647));
        add_row("PT2147483648S", 0, -1, 1, dur(1, 0, 0, 0, 0, 0, 0));
        add_row("P99999999999999999999D", 1, -1, 1, dur(1, 0, 0, 0, 0, 0, 0));
        add_row("P0000000000000000000001W", 0, -1, 1, dur(1, 0, 1, 0, 0, 0, 0));
        add_row("", 1, -1, 1, NO_DURATION);
        add_row("P", 0, -1, 1, NO_DURATION);
        add_row("P5DX", 0, -1, 0, NO_DURATION);
        add_row("P5D7", 0, -1, 0, NO_DURATION);
        add_row("PT5X", 0, -1, 0, NO_DURATION);
        add_row("PT5", 1, -1, 0, NO_DURATION);
        add_row("P5d", 0, -1, 1, NO_DURATION);
        add_row("P1W2D", 0, -1, 1, NO_DURATION);
        add_row("PT1H2S", 0, -1, 1, NO_DURATION);
        add_row("P\300", 0, -1, 1, NO_DURATION);
        add_row("P1D\326", 1, -1, 0, NO_DURATION);
        add_row("P1D\327", 0, -1, 1, NO_DURATION);
        add_row("\377P1W", 0, -1, 1, NO_DURATION);
        add_row("-P1W", 0, 2, 0, NO_DURATION);
        add_row("PT", 0, -1, 1, NO_DURATION);
        add_row("P1DT", 1, -1, 1, NO_DURATION);
        add_row("+-P1W", 0, -1, 1, NO_DURATION);
        add_row("P1H", 0, -1, 1, NO_DURATION);
        add_row("PT3M4S", 0, -1, 0, NO_DURATION);
        add_row("P7DT8S", 0, -1, 0, NO_DURATION);
        add_row("P1DT2H", 0, -1, 0, NO_DURATION);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[r]) begin
            text_buf.delete();
            for (int k = 0; k < rows[r].text.len(); k++) text_buf.push_back(rows[r].text[k]);
            send_string(rows[r].bare_end, rows[r].idle_at, rows[r].typed, rows[r].want);
        end
        drain_wait();

        while (rnd_items < RANDOM_ITEMS) begin
            build_text();
            bare = (text_buf.size() == 0) || ($urandom_range(0, 3) == 0);
            idle_at = (text_buf.size() != 0 && $urandom_range(0, 9) == 0) ?
                      $urandom_range(0, text_buf.size() - 1) : -1;
            send_string(bare, idle_at, 1'b0, NO_DURATION);
            rnd_items += text_buf.size() + (bare ? 1 : 0);
            if (!drained && rnd_items >= RANDOM_ITEMS / 2) begin
                drain_wait();
                drained = 1'b1;
            end
        end

        i_valid <= 1'b0;
        while (expected_durations.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);

        $display("Run covered %0d strings, %0d characters, %0d random items,",
                 strings_sent, char_cnt, rnd_items);
        $display("with %0d results compared and %0d field errors", results_checked, err_cnt);
        if (err_cnt == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
rtl/dsparse_pkg.sv
rtl/dsparse_front.sv
rtl/dsparse_fifo.sv
rtl/dsparse_back.sv
rtl/duration_string_parser.sv
rtl/dsparse_checker.sv
bench/tb_duration_string_parser.sv
